// ===== rtl/core/triangle_tangent_binormal_top_macros.svh =====
// Assertion macros for the triangle tangent and binormal block.
`ifndef TRIANGLE_TANGENT_BINORMAL_TOP_MACROS_SVH
`define TRIANGLE_TANGENT_BINORMAL_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define TTB_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define TTB_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ===== rtl/core/ttb_pkg.sv =====
// Package with shared types and constants of the triangle tangent block.
`default_nettype none
package ttb_pkg;
    localparam int INDEX_BITS_DEF = 16;
    localparam int QDEPTH = 2;
    localparam int DIV_STEPS = 80;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_DIV,
        BK_OUT
    } bk_state_t;

    typedef struct packed {
        logic signed [31:0] e1x, e1y, e1z, e2x, e2y, e2z;
        logic signed [31:0] d1u, d1v, d2u, d2v;
    } tri_t;

    function automatic logic signed [31:0] sat_diff(input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
        logic signed [32:0] d;
        d = 33'(a) - 33'(b);
        if (d[32] != d[31])
            sat_diff = d[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            sat_diff = d[31:0];
    endfunction
endpackage
`default_nettype wire

// ===== rtl/core/ttb_if.sv =====
// Valid/ready stream interface carrying a payload.
`default_nettype none
interface ttb_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ttb_front.sv =====
// Front end: holds the first two corners and forms edges and deltas.
`default_nettype none
module ttb_front #(parameter int INDEX_BITS = ttb_pkg::INDEX_BITS_DEF) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [INDEX_BITS-1:0] in_index,
    input  wire logic signed [31:0]    in_px,
    input  wire logic signed [31:0]    in_py,
    input  wire logic signed [31:0]    in_pz,
    input  wire logic signed [31:0]    in_u,
    input  wire logic signed [31:0]    in_v,
    output logic                       q_valid,
    input  wire logic                  q_ready,
    output logic [INDEX_BITS-1:0]      q_index,
    output ttb_pkg::tri_t              q_tri
);
    logic [1:0] count_reg;
    logic signed [31:0] p0x_reg, p0y_reg, p0z_reg, p1x_reg, p1y_reg, p1z_reg;
    logic signed [31:0] t0u_reg, t0v_reg, t1u_reg, t1v_reg;
    logic [INDEX_BITS-1:0] idx_reg;
    logic take;

    assign in_ready = (count_reg != 2'd2) || q_ready;
    assign take = in_valid && in_ready;
    assign q_valid = in_valid && (count_reg == 2'd2);
    assign q_index = idx_reg;

    always_comb
    begin
        q_tri.e1x = ttb_pkg::sat_diff(p1x_reg, p0x_reg);
        q_tri.e1y = ttb_pkg::sat_diff(p1y_reg, p0y_reg);
        q_tri.e1z = ttb_pkg::sat_diff(p1z_reg, p0z_reg);
        q_tri.e2x = ttb_pkg::sat_diff(in_px, p0x_reg);
        q_tri.e2y = ttb_pkg::sat_diff(in_py, p0y_reg);
        q_tri.e2z = ttb_pkg::sat_diff(in_pz, p0z_reg);
        q_tri.d1u = ttb_pkg::sat_diff(t1u_reg, t0u_reg);
        q_tri.d1v = ttb_pkg::sat_diff(t1v_reg, t0v_reg);
        q_tri.d2u = ttb_pkg::sat_diff(in_u, t0u_reg);
        q_tri.d2v = ttb_pkg::sat_diff(in_v, t0v_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else if (take)
            count_reg <= (count_reg == 2'd2) ? 2'd0 : count_reg + 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (take && count_reg == 2'd0)
        begin
            idx_reg <= in_index;
            p0x_reg <= in_px;
            p0y_reg <= in_py;
            p0z_reg <= in_pz;
            t0u_reg <= in_u;
            t0v_reg <= in_v;
        end
        if (take && count_reg == 2'd1)
        begin
            p1x_reg <= in_px;
            p1y_reg <= in_py;
            p1z_reg <= in_pz;
            t1u_reg <= in_u;
            t1v_reg <= in_v;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/ttb_queue.sv =====
// Two-entry queue between the front and back parts.
`default_nettype none
module ttb_queue #(parameter int W = 8) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         wr_valid,
    output logic              wr_ready,
    input  wire logic [W-1:0] wr_data,
    output logic              rd_valid,
    input  wire logic         rd_ready,
    output logic [W-1:0]      rd_data
);
    logic [W-1:0] mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic wr, rd;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr) wp_reg <= ~wp_reg;
            if (rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr) mem_reg[wp_reg] <= wr_data;
    end
endmodule
`default_nettype wire

// ===== rtl/core/ttb_back.sv =====
// Back end: products, determinant and a shared restoring divider.
`default_nettype none
module ttb_back #(parameter int INDEX_BITS = ttb_pkg::INDEX_BITS_DEF) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  q_valid,
    output logic                       q_ready,
    input  wire logic [INDEX_BITS-1:0] q_index,
    input  ttb_pkg::tri_t              q_tri,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [INDEX_BITS-1:0]      out_index,
    output logic signed [31:0]         out_vec [6],
    output logic                       out_degen
);
    localparam int SB = $clog2(ttb_pkg::DIV_STEPS);

    ttb_pkg::bk_state_t state_reg, state_next;
    ttb_pkg::tri_t t_reg;
    logic [INDEX_BITS-1:0] idx_reg;
    logic [3:0] mcnt_reg;             // multiply step 0..14
    logic signed [63:0] pa_reg;
    logic signed [63:0] num_reg [6];
    logic signed [63:0] det_reg;
    logic [2:0] comp_reg;
    logic [SB-1:0] step_reg;
    logic [63:0] n_reg, d_reg;
    logic [64:0] r_reg;
    logic [40:0] q_reg;
    logic sat_reg, neg_reg;
    logic signed [31:0] res_reg [6];
    logic degen_reg;

    logic signed [31:0] ma, mb;
    logic signed [63:0] prod;
    logic [64:0] r_sh;
    logic [64:0] r_sub;
    logic        bitin;
    logic [40:0] qlim;
    logic [40:0] qfin;
    logic [31:0] qres;
    logic signed [63:0] nsel;

    assign q_ready = state_reg == ttb_pkg::BK_IDLE;
    assign out_valid = state_reg == ttb_pkg::BK_OUT;
    assign out_index = idx_reg;
    assign out_vec = res_reg;
    assign out_degen = degen_reg;

    // Products in order: det (2), then per component tangent (2), binormal (2).
    always_comb
    begin
        ma = t_reg.d1u;
        mb = t_reg.d2v;
        unique case (mcnt_reg)
            4'd0: begin ma = t_reg.d1u; mb = t_reg.d2v; end
            4'd1: begin ma = t_reg.d2u; mb = t_reg.d1v; end
            4'd2: begin ma = t_reg.d2v; mb = t_reg.e1x; end
            4'd3: begin ma = t_reg.d1v; mb = t_reg.e2x; end
            4'd4: begin ma = t_reg.d1u; mb = t_reg.e2x; end
            4'd5: begin ma = t_reg.d2u; mb = t_reg.e1x; end
            4'd6: begin ma = t_reg.d2v; mb = t_reg.e1y; end
            4'd7: begin ma = t_reg.d1v; mb = t_reg.e2y; end
            4'd8: begin ma = t_reg.d1u; mb = t_reg.e2y; end
            4'd9: begin ma = t_reg.d2u; mb = t_reg.e1y; end
            4'd10: begin ma = t_reg.d2v; mb = t_reg.e1z; end
            4'd11: begin ma = t_reg.d1v; mb = t_reg.e2z; end
            4'd12: begin ma = t_reg.d1u; mb = t_reg.e2z; end
            4'd13: begin ma = t_reg.d2u; mb = t_reg.e1z; end
            default: begin ma = t_reg.d1u; mb = t_reg.d2v; end
        endcase
        prod = ma * mb;
    end

    always_comb
    begin
        bitin = (step_reg <= SB'(64)) ? n_reg[63] : 1'b0;
        r_sh = {r_reg[63:0], bitin};
        r_sub = r_sh - {1'b0, d_reg};
        qlim = neg_reg ? 41'h0_8000_0000 : 41'h0_7FFF_FFFF;
        qfin = (sat_reg || q_reg > qlim) ? qlim : q_reg;
        qres = neg_reg ? 32'(41'd0 - qfin) : qfin[31:0];
        nsel = num_reg[comp_reg];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ttb_pkg::BK_IDLE: if (q_valid) state_next = ttb_pkg::BK_MUL;
            ttb_pkg::BK_MUL:
                if (mcnt_reg == 4'd14)
                    state_next = (det_reg == 64'sd0) ? ttb_pkg::BK_OUT : ttb_pkg::BK_DIV;
            ttb_pkg::BK_DIV:
                if (step_reg == SB'(ttb_pkg::DIV_STEPS + 1) && comp_reg == 3'd5)
                    state_next = ttb_pkg::BK_OUT;
            ttb_pkg::BK_OUT: if (out_ready) state_next = ttb_pkg::BK_IDLE;
            default: state_next = ttb_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ttb_pkg::BK_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ttb_pkg::BK_IDLE:
                if (q_valid)
                begin
                    t_reg <= q_tri;
                    idx_reg <= q_index;
                    mcnt_reg <= 4'd0;
                end
            ttb_pkg::BK_MUL:
            begin
                if (mcnt_reg != 4'd14)
                begin
                    mcnt_reg <= mcnt_reg + 4'd1;
                    if (mcnt_reg[0] == 1'b0)
                        pa_reg <= prod;
                    else
                    begin
                        if (mcnt_reg == 4'd1) det_reg <= pa_reg - prod;
                        else num_reg[3'(mcnt_reg[3:2] - 2'd0) * 3'd0 +
                            3'((mcnt_reg - 4'd2) >> 2) + (mcnt_reg[1] ? 3'd0 : 3'd3)]
                            <= pa_reg - prod;
                    end
                end
                degen_reg <= det_reg == 64'sd0;
                comp_reg <= 3'd0;
                step_reg <= '0;
                for (int i = 0; i < 6; i++) res_reg[i] <= 32'sd0;
            end
            ttb_pkg::BK_DIV:
            begin
                if (step_reg == '0)
                begin
                    n_reg <= nsel[63] ? 64'd0 - 64'(nsel) : 64'(nsel);
                    d_reg <= det_reg[63] ? 64'd0 - 64'(det_reg) : 64'(det_reg);
                    neg_reg <= nsel[63] != det_reg[63];
                    r_reg <= '0;
                    q_reg <= '0;
                    sat_reg <= 1'b0;
                    step_reg <= step_reg + SB'(1);
                end
                else if (step_reg <= SB'(ttb_pkg::DIV_STEPS))
                begin
                    n_reg <= {n_reg[62:0], 1'b0};
                    if (q_reg[40]) sat_reg <= 1'b1;
                    if (!r_sub[64])
                    begin
                        r_reg <= r_sub;
                        q_reg <= {q_reg[39:0], 1'b1};
                    end
                    else
                    begin
                        r_reg <= r_sh;
                        q_reg <= {q_reg[39:0], 1'b0};
                    end
                    step_reg <= step_reg + SB'(1);
                end
                else
                begin
                    res_reg[comp_reg] <= qres;
                    comp_reg <= comp_reg + 3'd1;
                    step_reg <= '0;
                end
            end
            ttb_pkg::BK_OUT: ;
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/core/triangle_tangent_binormal_top.sv =====
// After its third corner transaction is accepted, a triangle passes through the queue,
// is loaded by the back end, runs the multiply steps and then six divisions; a degenerate
// triangle skips the divisions and its result is valid after the multiply steps.
// The back end works on one triangle at a time and the shared 1-bit divider is its slowest
// part; the first two corners are taken at once and a queue decouples front and back.
// Reset (rst_n low, asynchronous) clears the corner count, queue and back end state.
`default_nettype none
`include "triangle_tangent_binormal_top_macros.svh"
module triangle_tangent_binormal_top #(
    parameter int INDEX_BITS = ttb_pkg::INDEX_BITS_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    ttb_if.sink      corner,
    ttb_if.source    result
);
    localparam int QW = INDEX_BITS + $bits(ttb_pkg::tri_t);

    // The corner payload packs index, x, y, z, u, v from high to low bits;
    // the result payload packs index, tangent xyz, binormal xyz, degenerate.
    logic               f_valid, f_ready, b_valid, b_ready;
    logic [INDEX_BITS-1:0] f_index, b_index, o_index;
    ttb_pkg::tri_t      f_tri, b_tri;
    logic [QW-1:0]      b_data;
    logic signed [31:0] o_vec [6];
    logic               o_degen;

    ttb_front #(.INDEX_BITS(INDEX_BITS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(corner.valid), .in_ready(corner.ready),
        .in_index(corner.data[INDEX_BITS+159:160]),
        .in_px(corner.data[159:128]), .in_py(corner.data[127:96]),
        .in_pz(corner.data[95:64]), .in_u(corner.data[63:32]),
        .in_v(corner.data[31:0]),
        .q_valid(f_valid), .q_ready(f_ready),
        .q_index(f_index), .q_tri(f_tri)
    );

    ttb_queue #(.W(QW)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data({f_index, f_tri}),
        .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data)
    );

    assign b_index = b_data[QW-1:$bits(ttb_pkg::tri_t)];
    assign b_tri = b_data[$bits(ttb_pkg::tri_t)-1:0];

    ttb_back #(.INDEX_BITS(INDEX_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(b_valid), .q_ready(b_ready),
        .q_index(b_index), .q_tri(b_tri),
        .out_valid(result.valid), .out_ready(result.ready),
        .out_index(o_index), .out_vec(o_vec), .out_degen(o_degen)
    );

    assign result.data = {o_index, o_vec[0], o_vec[1], o_vec[2],
                          o_vec[3], o_vec[4], o_vec[5], o_degen};

    // A held result stays put until taken.
    `TTB_ASSERT_NEXT(a_hold, clk, rst_n, result.valid && !result.ready,
        result.valid && $stable(result.data))
    // A degenerate result carries zero vectors.
    `TTB_ASSERT_IMPL(a_degen, clk, rst_n, result.valid && result.data[0],
        result.data[192:1] == '0)
endmodule
`default_nettype wire
